>>> sv/slpg_pkg.sv
`timescale 1ns / 1ps

package slpg_pkg;

    localparam int TICK_W  = 24;
    localparam int PULSE_W = 8;
    localparam int COUNT_W = PULSE_W + 1;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = TICK_W;

    localparam logic [TICK_W-1:0]  TICK_MAX = {TICK_W{1'b1}};
    localparam logic [TICK_W-1:0]  LONG_HALF_RESET  = TICK_W'(2000000);
    localparam logic [TICK_W-1:0]  SHORT_HALF_RESET = TICK_W'(300000);
    localparam logic [PULSE_W-1:0] MARKER_PULSES_RESET = PULSE_W'(1);
    localparam logic               ON_LEVEL_RESET = 1'b1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LONG_HALF_PERIOD  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_HALF_PERIOD = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MARKER_PULSES     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ON_LEVEL          = CFG_IDX_W'(3);

    typedef struct packed {
        logic [TICK_W-1:0]  long_half_period;
        logic [TICK_W-1:0]  short_half_period;
        logic [PULSE_W-1:0] marker_pulses;
        logic               on_level;
    } cfg_t;

    typedef struct packed {
        logic led_level;
        logic led_lit;
        logic blinking;
    } result_t;

endpackage

>>> sv/slpg_cfg.sv
`timescale 1ns / 1ps

module slpg_cfg
    import slpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LONG_HALF_PERIOD:  cfg_next.long_half_period  = cfg_data;
                REG_SHORT_HALF_PERIOD: cfg_next.short_half_period = cfg_data;
                REG_MARKER_PULSES:     cfg_next.marker_pulses     = cfg_data[PULSE_W-1:0];
                REG_ON_LEVEL:          cfg_next.on_level          = cfg_data[0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_half_period  <= LONG_HALF_RESET;
            cfg_reg.short_half_period <= SHORT_HALF_RESET;
            cfg_reg.marker_pulses     <= MARKER_PULSES_RESET;
            cfg_reg.on_level          <= ON_LEVEL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> sv/slpg_core.sv
`timescale 1ns / 1ps

module slpg_core
    import slpg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    item_valid,
    input  logic    action,
    input  logic    sample,
    output result_t result
);

    logic [TICK_W-1:0]  elapsed_reg,     elapsed_next;
    logic               long_sel_reg,    long_sel_next;
    logic               marker_reg,      marker_next;
    logic               blink_act_reg,   blink_act_next;
    logic [COUNT_W-1:0] change_reg,      change_next;
    logic               drive_reg,       drive_next;
    logic               rest_reg,        rest_next;
    logic               blink_flag_reg,  blink_flag_next;

    logic [TICK_W-1:0]  period;
    logic [TICK_W-1:0]  elapsed_inc;
    logic               expire;
    logic [COUNT_W-1:0] end_count;
    logic               drive_base;

    assign period      = long_sel_reg ? cfg.long_half_period : cfg.short_half_period;
    assign elapsed_inc = (elapsed_reg == TICK_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    assign expire      = (elapsed_inc >= period);
    // marker ends after 2*N changes, one more when the rest level is lit
    assign end_count   = {cfg.marker_pulses, 1'b0}
                         + COUNT_W'(rest_reg == cfg.on_level);
    // first marker step starts from the on level
    assign drive_base  = long_sel_reg ? drive_reg : cfg.on_level;

    always_comb
    begin
        elapsed_next    = elapsed_reg;
        long_sel_next   = long_sel_reg;
        marker_next     = marker_reg;
        blink_act_next  = blink_act_reg;
        change_next     = change_reg;
        drive_next      = drive_reg;
        rest_next       = rest_reg;
        blink_flag_next = blink_flag_reg;
        if (item_valid)
        begin
            if (action)
            begin
                marker_next    = ~marker_reg;
                blink_act_next = ~blink_act_reg;
                change_next    = '0;
            end
            else if (!expire)
            begin
                elapsed_next = elapsed_inc;
            end
            else
            begin
                elapsed_next = '0;
                rest_next    = sample;
                if (marker_reg)
                begin
                    long_sel_next   = 1'b1;
                    drive_next      = ~drive_base;
                    change_next     = change_reg + 1'b1;
                    blink_flag_next = 1'b1;
                    if (change_next == end_count)
                    begin
                        marker_next = 1'b0;
                    end
                end
                else if (blink_act_reg)
                begin
                    long_sel_next = 1'b0;
                    drive_next    = ~drive_reg;
                end
                else
                begin
                    blink_flag_next = 1'b0;
                    drive_next      = rest_reg;
                end
            end
        end
    end

    always_comb
    begin
        result.led_level = drive_next;
        result.led_lit   = (drive_next == cfg.on_level);
        result.blinking  = blink_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg    <= '0;
            long_sel_reg   <= 1'b0;
            marker_reg     <= 1'b0;
            blink_act_reg  <= 1'b0;
            change_reg     <= '0;
            drive_reg      <= ON_LEVEL_RESET;
            rest_reg       <= ON_LEVEL_RESET;
            blink_flag_reg <= 1'b0;
        end
        else
        begin
            elapsed_reg    <= elapsed_next;
            long_sel_reg   <= long_sel_next;
            marker_reg     <= marker_next;
            blink_act_reg  <= blink_act_next;
            change_reg     <= change_next;
            drive_reg      <= drive_next;
            rest_reg       <= rest_next;
            blink_flag_reg <= blink_flag_next;
        end
    end

endmodule

>>> sv/sync_led_pattern_generator.sv
`timescale 1ns / 1ps
// LED pattern generator for marking recordings for optical tracking.
// Input channel (in_valid/in_ready): action = 0 is a one microsecond tick,
// action = 1 a start/stop trigger; default_level_in is the sampled rest level.
// Output channel (out_valid/out_ready): one result per input item giving the
// driven LED level, whether it is lit, and whether the pattern is active.
// Configuration channel (cfg_valid/cfg_ready): cfg_index selects the long
// half period, short half period, marker pulse count or on level; other
// indexes are ignored. cfg_ready is always high. Write only while idle.
// An accepted item lands in the input register, is evaluated against the
// pattern state once the result register is free, and its result is
// registered in the result register, where it is held until taken.
// Throughput: one item per cycle while results are taken; the single state
// update between the input and result registers sets this.
// A stalled receiver holds the result register; the input register still
// takes one more item, then in_ready drops until the result is taken.
// Reset clears all pattern state, sets the core's LED drive to the on level
// and loads the configuration defaults; no clearing pass is needed.

module sync_led_pattern_generator
    import slpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic                  default_level_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  led_level,
    output logic                  led_lit,
    output logic                  blinking,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    result_t core_result;
    result_t res_reg;

    logic in_valid_reg;
    logic action_reg;
    logic sample_reg;
    logic out_valid_reg;
    logic advance;

    slpg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // item moves from the input register into the result register
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    slpg_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (advance),
        .action     (action_reg),
        .sample     (sample_reg),
        .result     (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg <= action;
            sample_reg <= default_level_in;
        end
        if (advance)
        begin
            res_reg <= core_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign led_level = res_reg.led_level;
    assign led_lit   = res_reg.led_lit;
    assign blinking  = res_reg.blinking;

    // a held item is never dropped from the input register
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input register lost an item");

    // a pending result is not overwritten or dropped while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(res_reg))
        else $error("stalled result changed");

    // every evaluated item produces a valid result next cycle
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("evaluated item produced no result");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import slpg_pkg::*;

    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_TRIGGER = 1'b1;
    localparam logic [CFG_IDX_W-1:0] IDX_FIRST_UNUSED = REG_ON_LEVEL + 1'b1;

    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 200;
    localparam int TRIGGER_ODDS  = 50;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 3;
    localparam int QUIET_LIMIT   = 1000;

    typedef struct packed {
        logic act;
        logic level;
    } led_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  action = ACT_TICK;
    logic                  default_level_in = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  led_level;
    logic                  led_lit;
    logic                  blinking;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // pattern state mirrored by the predictor
    cfg_t               led_cfg;
    logic [TICK_W-1:0]  tick_cnt;
    logic               use_long;
    logic               in_marker;
    logic               in_blink;
    logic [COUNT_W-1:0] toggles;
    logic               pin_lvl;
    logic               rest_lvl;
    logic               pattern_on;

    led_item_t pending_items[$];
    result_t   expected_results[$];
    int        items_queued = 0;
    int        results_seen = 0;
    int        errors = 0;
    int        src_gap = 0;
    int        snk_stall = 0;
    bit        hold_done = 1'b0;
    bit        src_calm = 1'b0;
    bit        snk_calm = 1'b0;
    int        quiet = 0;

    sync_led_pattern_generator u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .default_level_in (default_level_in),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .led_level        (led_level),
        .led_lit          (led_lit),
        .blinking         (blinking),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic result_t advance_pattern(input logic act, input logic sampled);
        logic [TICK_W-1:0]  half;
        logic [COUNT_W-1:0] end_cnt;
        result_t            res;
        if (act == ACT_TRIGGER)
        begin
            in_marker = ~in_marker;
            in_blink  = ~in_blink;
            toggles   = '0;
        end
        else
        begin
            half = use_long ? led_cfg.long_half_period : led_cfg.short_half_period;
            if (tick_cnt != TICK_MAX)
                tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= half)
            begin
                tick_cnt = '0;
                if (in_marker)
                begin
                    // first marker step: switch to the long period, start from lit
                    if (!use_long)
                    begin
                        use_long = 1'b1;
                        pin_lvl  = led_cfg.on_level;
                    end
                    pin_lvl = ~pin_lvl;
                    toggles = toggles + 1'b1;
                    end_cnt = {led_cfg.marker_pulses, 1'b0};
                    if (rest_lvl == led_cfg.on_level)
                        end_cnt = end_cnt + 1'b1;
                    if (toggles == end_cnt)
                        in_marker = 1'b0;
                    pattern_on = 1'b1;
                end
                else if (in_blink)
                begin
                    use_long = 1'b0;
                    pin_lvl  = ~pin_lvl;
                end
                else
                begin
                    pattern_on = 1'b0;
                    pin_lvl    = rest_lvl;
                end
                rest_lvl = sampled;
            end
        end
        res.led_level = pin_lvl;
        res.led_lit   = (pin_lvl == led_cfg.on_level);
        res.blinking  = pattern_on;
        return res;
    endfunction

    function automatic void queue_item(input logic act, input logic level);
        led_item_t it;
        it.act   = act;
        it.level = level;
        pending_items.push_back(it);
        items_queued++;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_LONG_HALF_PERIOD:  led_cfg.long_half_period  = val;
            REG_SHORT_HALF_PERIOD: led_cfg.short_half_period = val;
            REG_MARKER_PULSES:     led_cfg.marker_pulses     = val[PULSE_W-1:0];
            REG_ON_LEVEL:          led_cfg.on_level          = val[0];
            default: ;
        endcase
    endtask

    // wait for every queued item to come back, then let the pipeline go quiet
    task automatic settle();
        while (results_seen != items_queued)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sender
    always @(posedge clk)
    begin
        logic      busy;
        led_item_t it;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            busy = in_valid;
            if (in_valid && in_ready)
            begin
                expected_results.push_back(advance_pattern(action, default_level_in));
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    it = pending_items.pop_front();
                    action           <= it.act;
                    default_level_in <= it.level;
                    in_valid         <= 1'b1;
                    src_gap = src_calm ? 0 : pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            snk_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_seen++;
                    if (led_level !== want.led_level)
                    begin
                        $error("led_level: expected %0b, got %0b", want.led_level, led_level);
                        errors++;
                    end
                    if (led_lit !== want.led_lit)
                    begin
                        $error("led_lit: expected %0b, got %0b", want.led_lit, led_lit);
                        errors++;
                    end
                    if (blinking !== want.blinking)
                    begin
                        $error("blinking: expected %0b, got %0b", want.blinking, blinking);
                        errors++;
                    end
                end
            end
            if (snk_stall > 0)
            begin
                snk_stall--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= 100 && pending_items.size() > 40)
            begin
                // long back-pressure so the block fills and stalls its input
                hold_done = 1'b1;
                snk_stall = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (snk_calm)
                out_ready <= 1'b1;
            else
            begin
                snk_stall = pick_gap();
                out_ready <= (snk_stall == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet = 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("[sync_led_pattern_generator] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int                 k;
        logic [TICK_W-1:0]  lp;
        logic [TICK_W-1:0]  sp;
        logic [PULSE_W-1:0] np;
        logic               ol;
        bit                 all_regs;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        led_cfg.long_half_period  = LONG_HALF_RESET;
        led_cfg.short_half_period = SHORT_HALF_RESET;
        led_cfg.marker_pulses     = MARKER_PULSES_RESET;
        led_cfg.on_level          = ON_LEVEL_RESET;
        tick_cnt   = '0;
        use_long   = 1'b0;
        in_marker  = 1'b0;
        in_blink   = 1'b0;
        toggles    = '0;
        pin_lvl    = ON_LEVEL_RESET;
        rest_lvl   = ON_LEVEL_RESET;
        pattern_on = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: periods far too long to expire here
        queue_item(ACT_TICK, 1'b0);
        queue_item(ACT_TICK, 1'b1);
        queue_item(ACT_TRIGGER, 1'b0);
        queue_item(ACT_TICK, 1'b1);
        queue_item(ACT_TRIGGER, 1'b1);
        queue_item(ACT_TICK, 1'b0);
        settle();

        // short marker with inverted on level, plus a write to an unused index
        write_reg(REG_LONG_HALF_PERIOD, TICK_W'(2));
        write_reg(REG_SHORT_HALF_PERIOD, TICK_W'(1));
        write_reg(REG_MARKER_PULSES, CFG_DATA_W'(1));
        write_reg(REG_ON_LEVEL, {{(CFG_DATA_W-1){1'b1}}, 1'b0});
        write_reg(IDX_FIRST_UNUSED, TICK_MAX);
        queue_item(ACT_TRIGGER, 1'b1);
        for (k = 0; k < 12; k++)
            queue_item(ACT_TICK, k[1]);
        queue_item(ACT_TRIGGER, 1'b0);
        for (k = 0; k < 4; k++)
            queue_item(ACT_TICK, k[0]);
        settle();

        for (k = 0; k < RAND_PHASES; k++)
        begin
            all_regs = 1'b1;
            case (k)
                0:
                begin
                    // zero long period: every tick steps; widest marker
                    lp = '0;       sp = TICK_W'(1); np = 8'd255; ol = 1'b1;
                end
                1:
                begin
                    // narrower marker: a count already past its end wraps around
                    lp = TICK_W'(1); sp = TICK_W'(3); np = 8'd2;   ol = 1'b0;
                end
                2:
                begin
                    lp = TICK_MAX; sp = TICK_W'(2); np = 8'd1;   ol = 1'b1;
                end
                3:
                begin
                    lp = TICK_W'(5); sp = TICK_MAX; np = 8'd3;   ol = 1'b0;
                end
                default:
                begin
                    lp = TICK_W'($urandom_range(1, 6));
                    sp = TICK_W'($urandom_range(1, 6));
                    np = PULSE_W'($urandom_range(1, 4));
                    ol = 1'($urandom_range(1));
                    all_regs = 1'b0;
                end
            endcase
            if (all_regs || $urandom_range(1))
                write_reg(REG_LONG_HALF_PERIOD, lp);
            if (all_regs || $urandom_range(1))
                write_reg(REG_SHORT_HALF_PERIOD, sp);
            if (all_regs || $urandom_range(1))
                write_reg(REG_MARKER_PULSES, {(CFG_DATA_W-PULSE_W)'($urandom), np});
            if (all_regs || $urandom_range(1))
                write_reg(REG_ON_LEVEL, {(CFG_DATA_W-1)'($urandom), ol});
            if ($urandom_range(1))
                write_reg(CFG_IDX_W'($urandom_range(IDX_FIRST_UNUSED, 255)),
                          CFG_DATA_W'($urandom));
            src_calm = (k % 3 == 1);
            snk_calm = (k % 3 == 2);
            repeat (PHASE_ITEMS)
                queue_item(($urandom_range(TRIGGER_ODDS - 1) == 0) ? ACT_TRIGGER : ACT_TICK,
                           1'($urandom_range(1)));
            settle();
        end

        if (errors == 0)
            $display("[sync_led_pattern_generator] OK");
        else
            $display("[sync_led_pattern_generator] ERROR");
        $finish;
    end

endmodule
